/* sv/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Shared shorthand for clocked implication checks with async reset disable.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: whenever ante holds, cons must hold too.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication: whenever ante holds, cons must hold in the next cycle.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

/* sv/c39enc_pkg.sv */
// ---------------------------------------------------------------------------
// c39enc_pkg
// Types, constants and lookup functions for the Code 39 encoder.
// ---------------------------------------------------------------------------
`default_nettype none

package c39enc_pkg;

  localparam int unsigned NUM_SYM   = 43;
  localparam int unsigned VAL_W     = 6;
  localparam int unsigned PAT_W     = 9;
  localparam logic [PAT_W-1:0] FRAME_PAT = 9'h094;

  // Segment codes: bit positions in a job's segment mask, emitted low to high.
  localparam int unsigned SEG_START = 0;
  localparam int unsigned SEG_CHAR  = 1;
  localparam int unsigned SEG_CHECK = 2;
  localparam int unsigned SEG_STOP  = 3;
  localparam int unsigned SEG_N     = 4;

  typedef struct packed {
    logic             invalid;
    logic [SEG_N-1:0] mask;
    logic [VAL_W-1:0] char_val;
    logic [VAL_W-1:0] chk_val;
  } job_t;

  typedef struct packed {
    logic             hit;
    logic [VAL_W-1:0] val;
  } lookup_t;

  // ASCII byte to Code 39 value, lower case folded to upper case.
  function automatic lookup_t char_lookup(input logic [7:0] ch);
    lookup_t    r;
    logic [7:0] d;
    r = '{hit: 1'b1, val: '0};
    d = '0;
    case (ch) inside
      [8'h30:8'h39]: d = ch - 8'd48;
      [8'h41:8'h5A]: d = ch - 8'd55;
      [8'h61:8'h7A]: d = ch - 8'd87;
      8'h2D:         d = 8'd36;
      8'h2E:         d = 8'd37;
      8'h20:         d = 8'd38;
      8'h24:         d = 8'd39;
      8'h2F:         d = 8'd40;
      8'h2B:         d = 8'd41;
      8'h25:         d = 8'd42;
      default:       r.hit = 1'b0;
    endcase
    r.val = d[VAL_W-1:0];
    return r;
  endfunction

  // Nine-element bar/space pattern, bit 8 first, 1 = wide.
  function automatic logic [PAT_W-1:0] sym_pattern(input logic [VAL_W-1:0] v);
    logic [PAT_W-1:0] p;
    case (v)
      6'd0:    p = 9'h034;
      6'd1:    p = 9'h121;
      6'd2:    p = 9'h061;
      6'd3:    p = 9'h160;
      6'd4:    p = 9'h031;
      6'd5:    p = 9'h130;
      6'd6:    p = 9'h070;
      6'd7:    p = 9'h025;
      6'd8:    p = 9'h124;
      6'd9:    p = 9'h064;
      6'd10:   p = 9'h109;
      6'd11:   p = 9'h049;
      6'd12:   p = 9'h148;
      6'd13:   p = 9'h019;
      6'd14:   p = 9'h118;
      6'd15:   p = 9'h058;
      6'd16:   p = 9'h00D;
      6'd17:   p = 9'h10C;
      6'd18:   p = 9'h04C;
      6'd19:   p = 9'h01C;
      6'd20:   p = 9'h103;
      6'd21:   p = 9'h043;
      6'd22:   p = 9'h142;
      6'd23:   p = 9'h013;
      6'd24:   p = 9'h112;
      6'd25:   p = 9'h052;
      6'd26:   p = 9'h007;
      6'd27:   p = 9'h106;
      6'd28:   p = 9'h046;
      6'd29:   p = 9'h016;
      6'd30:   p = 9'h181;
      6'd31:   p = 9'h0C1;
      6'd32:   p = 9'h1C0;
      6'd33:   p = 9'h091;
      6'd34:   p = 9'h190;
      6'd35:   p = 9'h0D0;
      6'd36:   p = 9'h085;
      6'd37:   p = 9'h184;
      6'd38:   p = 9'h0C4;
      6'd39:   p = 9'h0A8;
      6'd40:   p = 9'h0A2;
      6'd41:   p = 9'h08A;
      6'd42:   p = 9'h02A;
      default: p = '0;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

/* sv/c39enc_front.sv */
// ---------------------------------------------------------------------------
// c39enc_front
// Classifies message bytes, tracks message state and mod-43 sum, builds jobs.
// ---------------------------------------------------------------------------
`default_nettype none

module c39enc_front import c39enc_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic       cfg_wdata_i,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] in_char_i,
  input  wire logic       in_eom_i,
  output logic            job_valid_o,
  input  wire logic       job_ready_i,
  output job_t            job_o
);

  logic             check_en_q;
  logic             in_msg_q, in_msg_d;
  logic [VAL_W-1:0] sum_q, sum_d;

  lookup_t          lk;
  logic [VAL_W-1:0] sum_base;
  logic [VAL_W:0]   sum_raw;
  logic [VAL_W-1:0] sum_new;
  logic             accept;

  assign lk       = char_lookup(in_char_i);
  assign sum_base = in_msg_q ? sum_q : '0;
  assign sum_raw  = {1'b0, sum_base} + {1'b0, lk.val};
  // both terms below 43, so one conditional subtract closes the modulus
  assign sum_new  = (sum_raw >= (VAL_W+1)'(NUM_SYM))
                    ? sum_raw[VAL_W-1:0] - VAL_W'(NUM_SYM)
                    : sum_raw[VAL_W-1:0];

  assign in_ready_o  = job_ready_i;
  assign job_valid_o = in_valid_i;
  assign accept      = in_valid_i && job_ready_i;

  always_comb begin
    job_o                 = '0;
    job_o.invalid         = !lk.hit;
    job_o.char_val        = lk.val;
    job_o.chk_val         = sum_new;
    job_o.mask[SEG_CHAR]  = 1'b1;
    job_o.mask[SEG_START] = lk.hit && !in_msg_q;
    job_o.mask[SEG_CHECK] = lk.hit && in_eom_i && check_en_q;
    job_o.mask[SEG_STOP]  = lk.hit && in_eom_i;
  end

  always_comb begin
    in_msg_d = in_msg_q;
    sum_d    = sum_q;
    if (accept) begin
      if (!lk.hit || in_eom_i) begin
        in_msg_d = 1'b0;
        sum_d    = '0;
      end else begin
        in_msg_d = 1'b1;
        sum_d    = sum_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      check_en_q <= 1'b0;
      in_msg_q   <= 1'b0;
      sum_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        check_en_q <= cfg_wdata_i;
      end
      in_msg_q <= in_msg_d;
      sum_q    <= sum_d;
    end
  end

endmodule

`default_nettype wire

/* sv/c39enc_fifo.sv */
// ---------------------------------------------------------------------------
// c39enc_fifo
// Short job queue between front and back; head is read combinationally.
// ---------------------------------------------------------------------------
`default_nettype none

module c39enc_fifo import c39enc_pkg::*; #(
  parameter int unsigned DEPTH = 2  // >= 2
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  output logic      ready_o,
  input  job_t      data_i,
  output logic      valid_o,
  input  wire logic pop_i,
  output job_t      data_o
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  job_t             mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_push, do_pop;

  assign ready_o = (cnt_q != CNT_W'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!do_push && do_pop) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

/* sv/c39enc_back.sv */
// ---------------------------------------------------------------------------
// c39enc_back
// Expands each job into its symbol words, one per cycle unless the output stalls, into an output reg.
// ---------------------------------------------------------------------------
`default_nettype none

module c39enc_back import c39enc_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        job_valid_i,
  output logic             job_pop_o,
  input  job_t             job_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [PAT_W-1:0] out_pattern_o,
  output logic             out_gap_o,
  output logic             out_invalid_o,
  output logic             out_last_o
);

  job_t             cur_q, cur_d;
  logic             cur_valid_q;
  logic             out_valid_q;
  logic [PAT_W-1:0] out_pat_q;
  logic             out_gap_q, out_inv_q, out_last_q;

  job_t             sel;
  logic             sel_valid;
  logic [SEG_N-1:0] low, rem;
  logic             advance, fire;
  logic [PAT_W-1:0] pat;

  // current job has priority; otherwise work straight from the queue head
  assign sel       = cur_valid_q ? cur_q : job_i;
  assign sel_valid = cur_valid_q || job_valid_i;
  assign low       = sel.mask & (~sel.mask + 1'b1);
  assign rem       = sel.mask & ~low;
  assign advance   = !out_valid_q || out_ready_i;
  assign fire      = advance && sel_valid;
  assign job_pop_o = fire && !cur_valid_q;

  // job minus the segment being emitted now
  always_comb begin
    cur_d      = sel;
    cur_d.mask = rem;
  end

  always_comb begin
    if (low[SEG_START] || low[SEG_STOP]) begin
      pat = FRAME_PAT;
    end else if (low[SEG_CHECK]) begin
      pat = sym_pattern(sel.chk_val);
    end else if (sel.invalid) begin
      pat = '0;
    end else begin
      pat = sym_pattern(sel.char_val);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      cur_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        out_valid_q <= sel_valid;
      end
      if (fire) begin
        cur_valid_q <= (rem != '0);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_pat_q  <= pat;
      out_gap_q  <= !low[SEG_STOP] && !sel.invalid;
      out_inv_q  <= sel.invalid;
      out_last_q <= (rem == '0);
      cur_q      <= cur_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_pattern_o = out_pat_q;
  assign out_gap_o     = out_gap_q;
  assign out_invalid_o = out_inv_q;
  assign out_last_o    = out_last_q;

endmodule

`default_nettype wire

/* sv/code39_symbol_encoder_unit.sv */
// ---------------------------------------------------------------------------
// code39_symbol_encoder_unit
// Code 39 encoder: message bytes in, bar/space symbol words out, mod-43 check.
// ---------------------------------------------------------------------------
//  channel   dir  handshake          payload
//  s_axis    in   tvalid / tready    tdata[7:0] character, tlast end of message
//  m_axis    out  tvalid / tready    tdata[8:0] pattern, [9] gap_after;
//                                    tuser invalid; tlast last word of item
//  cfg       in   cfg_we_i           cfg_wdata_i check_enable
//
//  The front end takes one byte per cycle whenever the job queue has room.
//  Each byte yields 1 to 4 words (start, character, check, stop); the back end
//  emits one word per cycle from its output register unless m_axis stalls.
//  Reset clears message state, check_enable, queue and output valid.
//  Output stalls back up through the queue to s_axis_tready_o.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module code39_symbol_encoder_unit import c39enc_pkg::*; #(
  parameter int unsigned FIFO_DEPTH = 2  // job queue entries, >= 2
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_wdata_i,      // [0] check_enable
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] character
  input  wire logic        s_axis_tlast_i,   // end_of_message
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [15:0]      m_axis_tdata_o,   // [8:0] pattern, [9] gap_after
  output logic             m_axis_tuser_o,   // [0] invalid
  output logic             m_axis_tlast_o    // last_of_run
);

  logic             job_push, job_ready;
  job_t             job_in;
  logic             head_valid, head_pop;
  job_t             head;
  logic [PAT_W-1:0] pattern;
  logic             gap_after;

  c39enc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_char_i   (s_axis_tdata_i),
    .in_eom_i    (s_axis_tlast_i),
    .job_valid_o (job_push),
    .job_ready_i (job_ready),
    .job_o       (job_in)
  );

  c39enc_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .ready_o (job_ready),
    .data_i  (job_in),
    .valid_o (head_valid),
    .pop_i   (head_pop),
    .data_o  (head)
  );

  c39enc_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .job_valid_i   (head_valid),
    .job_pop_o     (head_pop),
    .job_i         (head),
    .out_valid_o   (m_axis_tvalid_o),
    .out_ready_i   (m_axis_tready_i),
    .out_pattern_o (pattern),
    .out_gap_o     (gap_after),
    .out_invalid_o (m_axis_tuser_o),
    .out_last_o    (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {6'b0, gap_after, pattern};

  // An invalid word is alone in its run: blank pattern, no gap, last.
  `ASSERT_IMPL(a_invalid_word, clk_i, rst_ni,
               m_axis_tvalid_o && m_axis_tuser_o,
               m_axis_tlast_o && (m_axis_tdata_o == 16'h0000))
  // Missing gap on a valid word only happens on the stop frame, which ends a run.
  `ASSERT_IMPL(a_stop_frame, clk_i, rst_ni,
               m_axis_tvalid_o && !m_axis_tuser_o && !m_axis_tdata_o[9],
               m_axis_tlast_o && (m_axis_tdata_o[8:0] == FRAME_PAT))
  // Invalid jobs carry only the character segment.
  `ASSERT_IMPL(a_invalid_job, clk_i, rst_ni,
               job_push && job_ready && job_in.invalid,
               job_in.mask == SEG_N'(1 << SEG_CHAR))

endmodule

`default_nettype wire
